/* src/blh_pkg.sv */
// ----------------------------------------------------------------------------
// blh_pkg: shared types and constants for the battery level tracker
// Level codes, configuration layout, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package blh_pkg;

    // Field widths
    localparam int PCT_W  = 7;
    localparam int MARG_W = 6;
    localparam int DIV_W  = 8;
    localparam int AVG_W  = 14;
    localparam int IDX_W  = 3;

    // Reset values of the configuration registers
    localparam logic [PCT_W-1:0]  CRIT_RST     = 7'd20;
    localparam logic [PCT_W-1:0]  FULL_RST     = 7'd80;
    localparam logic [MARG_W-1:0] MARG_RST     = 6'd5;
    localparam logic [DIV_W-1:0]  DIV_NORM_RST = 8'd8;
    localparam logic [DIV_W-1:0]  DIV_CRIT_RST = 8'd4;
    localparam logic [DIV_W-1:0]  DIV_FULL_RST = 8'd4;

    // Percent scaling: samples are kept in hundredths
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [AVG_W-1:0] PCT_SCALE = 14'd100;

    // x / 100 == (x * 5243) >> 19 for every x below 43699
    localparam int               RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int               RECIP_SHIFT = 19;
    localparam int               PROD_W      = AVG_W + RECIP_W;

    // Restoring divider: one quotient bit per step
    localparam int               CNT_W     = 4;
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(AVG_W - 1);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_CRIT_THR  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_FULL_THR  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_HYST      = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DIV_NORM  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DIV_CRIT  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_DIV_FULL  = 3'd5;

    typedef enum logic [1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_CRITICAL = 2'd1,
        LVL_FULL     = 2'd2
    } t_level;

    typedef struct packed {
        logic [PCT_W-1:0]  crit_thr;
        logic [PCT_W-1:0]  full_thr;
        logic [MARG_W-1:0] hyst;
        logic [DIV_W-1:0]  div_norm;
        logic [DIV_W-1:0]  div_crit;
        logic [DIV_W-1:0]  div_full;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_UPDATE,
        ST_SCALE,
        ST_DECIDE,
        ST_DONE
    } t_ctrl_state;

    typedef struct packed {
        logic load;     // take the sample: seed or start the divider
        logic step;     // one divider step
        logic update;   // fold the quotient into the average
        logic scale;    // multiply by the reciprocal of 100
        logic decide;   // whole percent and level decision
    } t_dp_cmd;

    typedef struct packed {
        logic seeded;
        logic div_last;
    } t_dp_status;

endpackage

/* src/battery_level_hysteresis_fsm_unit.sv */
// ----------------------------------------------------------------------------
// battery_level_hysteresis_fsm_unit: battery level tracker top level
// A seeded sample takes 14 divider steps (one quotient bit per cycle), then
// update, scale and decide; the seeding sample starts at scale, an invalid
// one goes to the result directly. One sample at a time, the next accepted
// once the result is registered. Reset (synchronous, active low) restores
// the default configuration, normal level, zero average and unseeded flag.
// ----------------------------------------------------------------------------
module battery_level_hysteresis_fsm_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [blh_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [blh_pkg::DIV_W-1:0]     i_cfg_data,
    // Sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [blh_pkg::PCT_W-1:0]     i_battery_percent,
    input  logic                          i_sample_valid,
    // Result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_charge_state,
    output logic [blh_pkg::PCT_W-1:0]     o_smoothed_percent,
    output logic                          o_average_seeded
);
    import blh_pkg::*;

    t_cfg               r_cfg;
    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    t_level             w_level;
    logic [PCT_W-1:0]   w_pct;
    logic               w_emit;
    logic               w_out_free;

    logic               r_out_valid;
    logic [1:0]         r_out_state;
    logic [PCT_W-1:0]   r_out_pct;
    logic               r_out_seeded;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crit_thr <= CRIT_RST;
            r_cfg.full_thr <= FULL_RST;
            r_cfg.hyst     <= MARG_RST;
            r_cfg.div_norm <= DIV_NORM_RST;
            r_cfg.div_crit <= DIV_CRIT_RST;
            r_cfg.div_full <= DIV_FULL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CRIT_THR: r_cfg.crit_thr <= i_cfg_data[PCT_W-1:0];
                CFG_FULL_THR: r_cfg.full_thr <= i_cfg_data[PCT_W-1:0];
                CFG_HYST:     r_cfg.hyst     <= i_cfg_data[MARG_W-1:0];
                CFG_DIV_NORM: r_cfg.div_norm <= i_cfg_data;
                CFG_DIV_CRIT: r_cfg.div_crit <= i_cfg_data;
                CFG_DIV_FULL: r_cfg.div_full <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_ready;

    blh_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_sample_valid (i_sample_valid),
        .i_status       (w_status),
        .i_out_free     (w_out_free),
        .o_ready        (o_ready),
        .o_cmd          (w_cmd),
        .o_emit         (w_emit)
    );

    blh_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (w_cmd),
        .i_battery_percent (i_battery_percent),
        .o_status          (w_status),
        .o_level           (w_level),
        .o_pct             (w_pct)
    );

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_state  <= 2'(w_level);
            r_out_pct    <= w_pct;
            r_out_seeded <= w_status.seeded;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_charge_state     = r_out_state;
    assign o_smoothed_percent = r_out_pct;
    assign o_average_seeded   = r_out_seeded;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sample accepted while a previous one is in flight");

    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_charge_state != 2'd3))
        else $error("unused level code on result");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_smoothed_percent <= PCT_MAX))
        else $error("smoothed percent above 100");

    a_unseeded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_average_seeded) |-> (o_smoothed_percent == '0))
        else $error("non-zero average before seeding");

endmodule

/* src/blh_ctrl.sv */
// ----------------------------------------------------------------------------
// blh_ctrl: sequencing controller
// Walks a seeded sample through divide, update, scale and decide (a seeding
// one from scale on), and hands results to the output register once free.
// ----------------------------------------------------------------------------
module blh_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_sample_valid,
    input  blh_pkg::t_dp_status   i_status,
    input  logic                  i_out_free,
    output logic                  o_ready,
    output blh_pkg::t_dp_cmd      o_cmd,
    output logic                  o_emit
);
    import blh_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        w_accept;

    assign w_accept = i_valid && (r_state == ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_sample_valid) begin
                        n_state = ST_DONE;
                    end else if (i_status.seeded) begin
                        n_state = ST_DIVIDE;
                    end else begin
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready  = 1'b1;
                o_cmd.load = w_accept && i_sample_valid;
            end
            ST_DIVIDE: o_cmd.step   = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_SCALE:  o_cmd.scale  = 1'b1;
            ST_DECIDE: o_cmd.decide = 1'b1;
            ST_DONE:   o_emit       = i_out_free;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

/* src/blh_dp.sv */
// ----------------------------------------------------------------------------
// blh_dp: averaging datapath
// Holds the average, level and seed flag; a restoring divider for the
// per-level divisor and a reciprocal multiply for the whole percent.
// ----------------------------------------------------------------------------
module blh_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  blh_pkg::t_cfg                 i_cfg,
    input  blh_pkg::t_dp_cmd              i_cmd,
    input  logic [blh_pkg::PCT_W-1:0]     i_battery_percent,
    output blh_pkg::t_dp_status           o_status,
    output blh_pkg::t_level               o_level,
    output logic [blh_pkg::PCT_W-1:0]     o_pct
);
    import blh_pkg::*;

    // Architectural state
    t_level             r_level;
    logic [AVG_W-1:0]   r_avg;
    logic               r_seeded;
    logic [PCT_W-1:0]   r_pct;

    // Divider and multiplier working registers
    logic               r_neg;
    logic [AVG_W-1:0]   r_quo;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_dvs;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_prod;

    logic [PCT_W-1:0]   w_sat;
    logic [AVG_W-1:0]   w_sample;
    logic [AVG_W:0]     w_diff;
    logic [AVG_W-1:0]   w_mag;
    logic [DIV_W-1:0]   w_dsel;
    logic [DIV_W:0]     w_shift;
    logic [DIV_W+1:0]   w_trial;
    logic               w_ge;
    logic [PCT_W-1:0]   w_pct;
    logic [PCT_W:0]     w_pct8;
    logic [PCT_W:0]     w_crit_exit;
    logic [PCT_W:0]     w_full_test;
    t_level             w_level;

    // Sample saturation and scaling to hundredths
    assign w_sat    = (i_battery_percent > PCT_MAX) ? PCT_MAX : i_battery_percent;
    assign w_sample = AVG_W'(w_sat) * PCT_SCALE;

    // Signed difference and its magnitude
    assign w_diff = {1'b0, w_sample} - {1'b0, r_avg};
    assign w_mag  = w_diff[AVG_W] ? AVG_W'(-w_diff) : w_diff[AVG_W-1:0];

    // Divisor of the current level, zero treated as one
    always_comb begin
        unique case (r_level)
            LVL_CRITICAL: w_dsel = i_cfg.div_crit;
            LVL_FULL:     w_dsel = i_cfg.div_full;
            default:      w_dsel = i_cfg.div_norm;
        endcase
        if (w_dsel == '0) begin
            w_dsel = DIV_W'(1);
        end
    end

    // Restoring divider step
    assign w_shift = {r_rem, r_quo[AVG_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = !w_trial[DIV_W+1];

    // Whole percent and level decision
    assign w_pct       = r_prod[RECIP_SHIFT +: PCT_W];
    assign w_pct8      = {1'b0, w_pct};
    assign w_crit_exit = {1'b0, i_cfg.crit_thr} + {2'b00, i_cfg.hyst};
    assign w_full_test = w_pct8 + {2'b00, i_cfg.hyst};

    always_comb begin
        if (w_pct8 < {1'b0, i_cfg.crit_thr}) begin
            w_level = LVL_CRITICAL;
        end else if (w_pct8 >= {1'b0, i_cfg.full_thr}) begin
            w_level = LVL_FULL;
        end else if (r_level == LVL_CRITICAL) begin
            w_level = (w_pct8 >= w_crit_exit) ? LVL_NORMAL : LVL_CRITICAL;
        end else if (r_level == LVL_FULL) begin
            // pct < full - margin, without going negative
            w_level = (w_full_test < {1'b0, i_cfg.full_thr}) ? LVL_NORMAL : LVL_FULL;
        end else begin
            w_level = LVL_NORMAL;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= LVL_NORMAL;
            r_avg    <= '0;
            r_seeded <= 1'b0;
            r_pct    <= '0;
        end else begin
            if (i_cmd.load && !r_seeded) begin
                r_avg    <= w_sample;
                r_seeded <= 1'b1;
            end
            if (i_cmd.update) begin
                r_avg <= r_neg ? (r_avg - r_quo) : (r_avg + r_quo);
            end
            if (i_cmd.decide) begin
                r_pct   <= w_pct;
                r_level <= w_level;
            end
        end
    end

    // Divider and multiplier registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= w_diff[AVG_W];
            r_quo <= w_mag;
            r_rem <= '0;
            r_dvs <= w_dsel;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? w_trial[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[AVG_W-2:0], w_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.scale) begin
            r_prod <= PROD_W'(r_avg) * PROD_W'(RECIP_100);
        end
    end

    assign o_status.seeded   = r_seeded;
    assign o_status.div_last = (r_cnt == DIV_LAST);
    assign o_level           = r_level;
    assign o_pct             = r_pct;

endmodule
